/* sv/hdr_bracket_exposure_search_macros.svh */
`ifndef HDR_BRACKET_EXPOSURE_SEARCH_MACROS_SVH
`define HDR_BRACKET_EXPOSURE_SEARCH_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define HBES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define HBES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hbes_pkg.sv */
package hbes_pkg;

  // Request opcodes
  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_ABORT     = 2'd1;
  localparam logic [1:0] OP_PIXEL     = 2'd2;
  localparam logic [1:0] OP_FRAME_END = 2'd3;

  // Result events
  localparam logic [2:0] EV_IDLE        = 3'd0;
  localparam logic [2:0] EV_STEP_DOWN   = 3'd1;
  localparam logic [2:0] EV_STEP_UP     = 3'd2;
  localparam logic [2:0] EV_LOWER_FOUND = 3'd3;
  localparam logic [2:0] EV_UPPER_FOUND = 3'd4;
  localparam logic [2:0] EV_DONE        = 3'd5;
  localparam logic [2:0] EV_ERROR       = 3'd6;

  // Error codes
  localparam logic [1:0] ERR_UNDER_LIMIT = 2'd0;
  localparam logic [1:0] ERR_OVER_LIMIT  = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAP   = 3'd5;

  // Configuration reset values
  localparam logic [7:0] RST_BLACK = 8'd10;
  localparam logic [7:0] RST_WHITE = 8'd245;
  localparam logic [6:0] RST_OVER  = 7'd5;
  localparam logic [6:0] RST_UNDER = 7'd5;
  localparam logic [6:0] RST_MAXIM = 7'd7;
  localparam logic [4:0] RST_GAP   = 5'd2;

  // Percentage scale and criterion bounds
  localparam logic [6:0] PCT_MIN = 7'd1;
  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       camera_at_limit;
  } hbes_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] error_code;
    logic [6:0] exposure_rate;
    logic [7:0] stop_count;
    logic [6:0] shots_needed;
  } hbes_res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
  } hbes_cfg_t;

  // Pixel classification rule for the current phase
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_BRIGHT,
    CLS_DARK
  } cls_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       count_pixel;
    cls_e       cls;
    logic       frame_end;
    logic       load_rate;
    logic       load_shots;
    logic       low_side;
    logic       clear_stops;
    logic       inc_stops;
    logic       emit;
    logic [2:0] event_res;
    logic [1:0] error_code;
    logic       show_rate;
    logic       shots_one;
    logic       shots_quot;
  } hbes_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pix_empty;
    logic stops_zero;
    logic div_busy;
    logic rate_below;
    logic shots_over;
  } hbes_stat_t;

endpackage

/* sv/hbes_chan_if.sv */
interface hbes_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/hdr_bracket_exposure_search.sv */
// Start, abort and pixel requests never stall the input; pixels stream at one per cycle while input is not held off.
// A frame end in a search phase with a non-empty frame, or the last frame end with stops
// taken, runs the bit-serial divider on a D-bit quotient, D = max(PIXEL_COUNT_BITS+7,
// max(STOP_COUNT_BITS,5)+1). Other frame ends answer next cycle.
// Input is held off while the divider runs or a result waits to be taken.
// Reset clears phase to idle, all counters, and loads the register defaults.
`include "hdr_bracket_exposure_search_macros.svh"

module hdr_bracket_exposure_search import hbes_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = 24,
  parameter int STOP_COUNT_BITS  = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hbes_chan_if.sink    in_i,
  hbes_chan_if.source  res_o,
  hbes_chan_if.sink    cfg_i
);

  hbes_cmd_t  cmd;
  hbes_stat_t stat;
  hbes_res_t  res;
  hbes_in_t   pix;
  hbes_cfg_t  cfg;
  logic       in_ready;
  logic       res_valid;

  assign pix         = in_i.data;
  assign cfg         = cfg_i.data;
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res;

  hbes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (pix.opcode),
    .at_limit_i  (pix.camera_at_limit),
    .res_ready_i (res_o.ready),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .res_valid_o (res_valid),
    .cmd_o       (cmd)
  );

  hbes_dp #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .STOP_COUNT_BITS  (STOP_COUNT_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_i.valid),
    .cfg_i    (cfg),
    .pix_i    (pix),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .res_o    (res)
  );

  // Checks
  `HBES_ASSERT_NOW(a_div_blocks_input, clk_i, rst_ni, stat.div_busy, !in_ready, "input taken while dividing")
  `HBES_ASSERT_NEXT(a_frame_end_stalls, clk_i, rst_ni, in_i.valid && in_ready && pix.opcode == OP_FRAME_END, !in_ready, "no stall after frame end")
  `HBES_ASSERT_NOW(a_error_code_clean, clk_i, rst_ni, res_valid && res.event_res != EV_ERROR, res.error_code == ERR_UNDER_LIMIT, "error code without error")
  `HBES_ASSERT_NOW(a_done_has_shots, clk_i, rst_ni, res_valid && res.event_res == EV_DONE, res.shots_needed != 7'd0, "done with zero shots")

endmodule

/* sv/hbes_dp.sv */
module hbes_dp import hbes_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = 24,
  parameter int STOP_COUNT_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  hbes_cfg_t  cfg_i,
  input  hbes_in_t   pix_i,
  input  hbes_cmd_t  cmd_i,
  output hbes_stat_t stat_o,
  output hbes_res_t  res_o
);

  localparam int PW    = PIXEL_COUNT_BITS;
  localparam int SW    = STOP_COUNT_BITS;
  localparam int SSW   = ((SW > 5) ? SW : 5) + 1;
  localparam int DW    = ((PW + 7) > SSW) ? (PW + 7) : SSW;
  localparam int DNW   = (PW > 5) ? PW : 5;
  localparam int CNT_W = $clog2(DW + 1);

  logic [7:0] black_q, white_q;
  logic [6:0] over_q, under_q, maxim_q;
  logic [4:0] gap_q;

  logic [PW-1:0]    pix_q, pix_d, flag_q, flag_d;
  logic [SW-1:0]    stops_q, stops_d;
  logic [DW-1:0]    num_q, num_d;
  logic [DNW-1:0]   rem_q, rem_d, den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  hbes_res_t        res_q;

  logic           hit, pix_full;
  logic [4:0]     gap_eff;
  logic [DW-1:0]  flag_ext, rate_num, shots_num;
  logic [DNW:0]   rem_sh, rem_sub;
  logic           ge;
  logic [6:0]     crit_raw, crit, rate;
  logic [DW:0]    quot_inc;
  logic [SW+7:0]  stops_ext;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= RST_BLACK;
      white_q <= RST_WHITE;
      over_q  <= RST_OVER;
      under_q <= RST_UNDER;
      maxim_q <= RST_MAXIM;
      gap_q   <= RST_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_i.reg_idx)
        REG_BLACK: black_q <= cfg_i.wdata;
        REG_WHITE: white_q <= cfg_i.wdata;
        REG_OVER:  over_q  <= cfg_i.wdata[6:0];
        REG_UNDER: under_q <= cfg_i.wdata[6:0];
        REG_MAXIM: maxim_q <= cfg_i.wdata[6:0];
        REG_GAP:   gap_q   <= cfg_i.wdata[4:0];
        default: ;
      endcase
    end
  end

  // Classify the pixel against the rule of the current phase
  always_comb begin
    case (cmd_i.cls)
      CLS_BRIGHT: hit = (pix_i.red >= white_q) || (pix_i.green >= white_q) ||
                        (pix_i.blue >= white_q);
      CLS_DARK:   hit = (pix_i.red <= black_q) && (pix_i.green <= black_q) &&
                        (pix_i.blue <= black_q);
      default:    hit = 1'b0;
    endcase
  end

  assign pix_full = &pix_q;

  // Pixel counters: hold at full, clear on frame end
  always_comb begin
    pix_d  = pix_q;
    flag_d = flag_q;
    if (cmd_i.frame_end) begin
      pix_d  = '0;
      flag_d = '0;
    end else if (cmd_i.count_pixel && !pix_full) begin
      pix_d = pix_q + PW'(1);
      if (hit) begin
        flag_d = flag_q + PW'(1);
      end
    end
  end

  // Stop counter, saturating
  always_comb begin
    stops_d = stops_q;
    if (cmd_i.clear_stops) begin
      stops_d = '0;
    end else if (cmd_i.inc_stops && !(&stops_q)) begin
      stops_d = stops_q + SW'(1);
    end
  end

  // Divider operands: flagged * 100 over total, or ceil(stops / gap)
  assign gap_eff   = (gap_q == 5'd0) ? 5'd1 : gap_q;
  assign flag_ext  = DW'(flag_q);
  assign rate_num  = (flag_ext << 6) + (flag_ext << 5) + (flag_ext << 2);
  assign shots_num = DW'(stops_q) + DW'(gap_eff) - DW'(1);

  // One restoring division step per cycle
  assign rem_sh  = {rem_q, num_q[DW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (cmd_i.load_rate) begin
      num_d = rate_num;
      den_d = DNW'(pix_q);
      rem_d = '0;
      cnt_d = CNT_W'(DW);
    end else if (cmd_i.load_shots) begin
      num_d = shots_num;
      den_d = DNW'(gap_eff);
      rem_d = '0;
      cnt_d = CNT_W'(DW);
    end else if (cnt_q != '0) begin
      num_d = {num_q[DW-2:0], ge};
      rem_d = rem_sub[DNW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q   <= '0;
      flag_q  <= '0;
      stops_q <= '0;
      cnt_q   <= '0;
    end else begin
      pix_q   <= pix_d;
      flag_q  <= flag_d;
      stops_q <= stops_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Compare the rate against the clamped criterion
  assign crit_raw = cmd_i.low_side ? over_q : under_q;
  assign crit     = (crit_raw < PCT_MIN) ? PCT_MIN :
                    (crit_raw > PCT_MAX) ? PCT_MAX : crit_raw;
  assign rate     = num_q[6:0];
  assign quot_inc = {1'b0, num_q} + (DW+1)'(1);

  assign stat_o.pix_empty  = (pix_q == '0);
  assign stat_o.stops_zero = (stops_q == '0);
  assign stat_o.div_busy   = (cnt_q != '0);
  assign stat_o.rate_below = rate < crit;
  assign stat_o.shots_over = quot_inc > (DW+1)'(maxim_q);

  // Result register
  assign stops_ext = {8'd0, stops_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.event_res     <= cmd_i.event_res;
      res_q.error_code    <= cmd_i.error_code;
      res_q.exposure_rate <= cmd_i.show_rate ? rate : 7'd0;
      res_q.stop_count    <= stops_ext[7:0];
      res_q.shots_needed  <= cmd_i.shots_one  ? 7'd1 :
                             cmd_i.shots_quot ? quot_inc[6:0] : 7'd0;
    end
  end

  assign res_o = res_q;

endmodule

/* sv/hbes_ctrl.sv */
module hbes_ctrl import hbes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] opcode_i,
  input  logic       at_limit_i,
  input  logic       res_ready_i,
  input  hbes_stat_t stat_i,
  output logic       in_ready_o,
  output logic       res_valid_o,
  output hbes_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_LOW_SEEK,
    PH_LOW_FOUND,
    PH_UP_SEEK,
    PH_UP_FOUND
  } phase_e;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_e;

  state_e st_q, st_d;
  phase_e phase_q, phase_d;
  logic   res_valid_q, res_valid_d;
  logic   low_q, low_d;
  logic   lim_q, lim_d;
  logic   shots_q, shots_d;
  logic   accept;

  assign in_ready_o = (st_q == ST_RUN) && !res_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    res_valid_d = res_valid_q && !res_ready_i;
    low_d       = low_q;
    lim_d       = lim_q;
    shots_d     = shots_q;
    cmd_o       = '0;
    cmd_o.cls   = CLS_NONE;
    cmd_o.low_side = low_q;

    unique case (st_q)
      ST_RUN: begin
        if (accept) begin
          unique case (opcode_i)
            OP_START: begin
              if (phase_q == PH_IDLE) begin
                phase_d = PH_START;
              end
            end
            OP_ABORT: phase_d = PH_IDLE;
            OP_PIXEL: begin
              cmd_o.count_pixel = 1'b1;
              if (phase_q == PH_LOW_SEEK) begin
                cmd_o.cls = CLS_BRIGHT;
              end else if (phase_q == PH_UP_SEEK) begin
                cmd_o.cls = CLS_DARK;
              end
            end
            OP_FRAME_END: begin
              cmd_o.frame_end = 1'b1;
              unique case (phase_q) inside
                PH_START: begin
                  cmd_o.clear_stops = 1'b1;
                  cmd_o.emit        = 1'b1;
                  phase_d           = PH_LOW_SEEK;
                end
                PH_LOW_FOUND: begin
                  cmd_o.emit = 1'b1;
                  phase_d    = PH_UP_SEEK;
                end
                PH_LOW_SEEK, PH_UP_SEEK: begin
                  // Skip rating of an empty frame
                  if (stat_i.pix_empty) begin
                    cmd_o.emit = 1'b1;
                  end else begin
                    cmd_o.load_rate = 1'b1;
                    low_d           = (phase_q == PH_LOW_SEEK);
                    lim_d           = at_limit_i;
                    shots_d         = 1'b0;
                    st_d            = ST_DIV;
                  end
                end
                PH_UP_FOUND: begin
                  phase_d = PH_IDLE;
                  if (stat_i.stops_zero) begin
                    cmd_o.emit      = 1'b1;
                    cmd_o.event_res = EV_DONE;
                    cmd_o.shots_one = 1'b1;
                  end else begin
                    cmd_o.load_shots = 1'b1;
                    shots_d          = 1'b1;
                    st_d             = ST_DIV;
                  end
                end
                default: begin
                  cmd_o.emit = 1'b1;
                  phase_d    = PH_IDLE;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // Decide once the quotient has settled
        if (!stat_i.div_busy) begin
          st_d       = ST_RUN;
          cmd_o.emit = 1'b1;
          if (shots_q) begin
            if (stat_i.shots_over) begin
              cmd_o.event_res  = EV_ERROR;
              cmd_o.error_code = ERR_TOO_MANY;
            end else begin
              cmd_o.event_res  = EV_DONE;
              cmd_o.shots_quot = 1'b1;
            end
          end else begin
            cmd_o.show_rate = 1'b1;
            if (stat_i.rate_below) begin
              cmd_o.event_res = low_q ? EV_LOWER_FOUND : EV_UPPER_FOUND;
              phase_d         = low_q ? PH_LOW_FOUND : PH_UP_FOUND;
            end else if (lim_q) begin
              cmd_o.event_res  = EV_ERROR;
              cmd_o.error_code = low_q ? ERR_UNDER_LIMIT : ERR_OVER_LIMIT;
              phase_d          = PH_IDLE;
            end else begin
              cmd_o.inc_stops = 1'b1;
              cmd_o.event_res = low_q ? EV_STEP_DOWN : EV_STEP_UP;
            end
          end
        end
      end
      default: st_d = ST_RUN;
    endcase

    if (cmd_o.emit) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_RUN;
      phase_q     <= PH_IDLE;
      res_valid_q <= 1'b0;
      low_q       <= 1'b0;
      lim_q       <= 1'b0;
      shots_q     <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      res_valid_q <= res_valid_d;
      low_q       <= low_d;
      lim_q       <= lim_d;
      shots_q     <= shots_d;
    end
  end

  assign res_valid_o = res_valid_q;

endmodule
